[rtl/core/rsp_pkg.sv]
`default_nettype none

package rsp_pkg;

  // Unit axis components carry this many fraction bits.
  localparam int AXIS_FRAC   = 16;
  localparam int AXIS_W      = AXIS_FRAC + 2;

  // Normalized edge magnitudes have their leading one at bit NORM_MSB.
  localparam int NORM_MSB    = 29;
  localparam int NORM_W      = NORM_MSB + 1;
  localparam int SQ_W        = 2 * NORM_W + 1;

  // Integer square root of a SQ_W-bit sum, one result bit per stage.
  localparam int ISQRT_W     = 62;
  localparam int ISQRT_STEPS = 31;
  localparam int ROOT_W      = 31;

  // Rounded division, one quotient bit per stage.
  localparam int DIV_W       = 48;
  localparam int DIV_STEPS   = 17;
  localparam int QUOT_W      = 17;

  localparam int NUM_AXES    = 4;
  localparam int NUM_CORNERS = 8;

  localparam int AXIS_LAT    = 4 + ISQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int RES_LAT     = 11;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } axis_t;

endpackage

`default_nettype wire

[rtl/core/rect_sat_push_vector.sv]
// Each item passes through the 31-step square-root pipeline and the 17-step
// divider inside each axis unit on its way from input accept to result valid.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken, and holds in place otherwise.
// Reset: rst_ni clears all valid bits asynchronously; data registers keep state.
`default_nettype none

module rect_sat_push_vector #(
  parameter int COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input item.
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // first_a_x, first_a_y, first_b_x, first_b_y, first_d_x, first_d_y,
  // second_a_x, second_a_y, second_b_x, second_b_y, second_d_x, second_d_y
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // Result item.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // push_x, push_y, overlapping, zero fill
  output logic [((2*COORD_BITS+8)/8)*8-1:0]     m_axis_tdata_o
);

  localparam int C      = COORD_BITS;
  localparam int EW     = C + 1;
  localparam int CW     = C + 2;
  localparam int NA     = rsp_pkg::NUM_AXES;
  localparam int NC     = rsp_pkg::NUM_CORNERS;
  localparam int AL     = rsp_pkg::AXIS_LAT;
  localparam int TOT    = 1 + AL + rsp_pkg::RES_LAT;
  localparam int OUT_W  = ((2*COORD_BITS+8)/8)*8;

  // Advance the whole pipeline when the output slot is free or drains now.
  logic adv;
  logic [TOT-1:0] vld_q;

  assign adv             = !vld_q[TOT-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[TOT-1];

  // Valid bits run alongside the data; a stall freezes them with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-2:0], s_axis_tvalid_i};
    end
  end

  // Unpack the twelve coordinates.
  logic signed [C-1:0] fin [12];

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      fin[i] = s_axis_tdata_i[i*C +: C];
    end
  end

  // Stage 1: edge vectors for the four axes and all eight corners.
  // Corner order per rectangle: a, b, c = b + d - a, d.
  // Axis order: first d-a, first b-a, second d-a, second b-a.
  logic signed [EW-1:0] dx_q [NA];
  logic signed [EW-1:0] dy_q [NA];
  logic signed [CW-1:0] cx0_q [NC];
  logic signed [CW-1:0] cy0_q [NC];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 2; r++) begin
        cx0_q[4*r]   <= CW'(fin[6*r]);
        cy0_q[4*r]   <= CW'(fin[6*r+1]);
        cx0_q[4*r+1] <= CW'(fin[6*r+2]);
        cy0_q[4*r+1] <= CW'(fin[6*r+3]);
        cx0_q[4*r+2] <= CW'(fin[6*r+2]) + CW'(fin[6*r+4]) - CW'(fin[6*r]);
        cy0_q[4*r+2] <= CW'(fin[6*r+3]) + CW'(fin[6*r+5]) - CW'(fin[6*r+1]);
        cx0_q[4*r+3] <= CW'(fin[6*r+4]);
        cy0_q[4*r+3] <= CW'(fin[6*r+5]);
        dx_q[2*r]    <= EW'(fin[6*r+4]) - EW'(fin[6*r]);
        dy_q[2*r]    <= EW'(fin[6*r+5]) - EW'(fin[6*r+1]);
        dx_q[2*r+1]  <= EW'(fin[6*r+2]) - EW'(fin[6*r]);
        dy_q[2*r+1]  <= EW'(fin[6*r+3]) - EW'(fin[6*r+1]);
      end
    end
  end

  // Four axis units: normalize, square root, divide, apply sign.
  rsp_pkg::axis_t ax [NA];

  for (genvar k = 0; k < NA; k++) begin : g_axis
    rsp_axis #(
      .COORD_BITS (C)
    ) u_axis (
      .clk_i (clk_i),
      .en_i  (adv),
      .dx_i  (dx_q[k]),
      .dy_i  (dy_q[k]),
      .ax_o  (ax[k])
    );
  end

  // Delay the corners to meet their axes.
  logic signed [CW-1:0] cdx_q [AL][NC];
  logic signed [CW-1:0] cdy_q [AL][NC];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cdx_q[0] <= cx0_q;
      cdy_q[0] <= cy0_q;
      for (int i = 1; i < AL; i++) begin
        cdx_q[i] <= cdx_q[i-1];
        cdy_q[i] <= cdy_q[i-1];
      end
    end
  end

  // Project, test for separation, keep the smallest push and scale the axis.
  logic signed [C-1:0] push_x, push_y;
  logic                overlap;

  rsp_resolve #(
    .COORD_BITS (C)
  ) u_resolve (
    .clk_i     (clk_i),
    .en_i      (adv),
    .cx_i      (cdx_q[AL-1]),
    .cy_i      (cdy_q[AL-1]),
    .ax_i      (ax),
    .push_x_o  (push_x),
    .push_y_o  (push_y),
    .overlap_o (overlap)
  );

  assign m_axis_tdata_o = {(OUT_W-2*C-1)'(0), overlap, push_y, push_x};

  // Overlap flag must agree with the push it goes out with.
  ap_overlap_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (overlap == ((push_x != '0) || (push_y != '0))))
    else $error("overlap flag disagrees with push vector");

  // A stalled pipeline keeps every in-flight item where it is.
  ap_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid chain moved during a stall");

  // An accepted item occupies the first stage on the next cycle.
  ap_accept_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire

[rtl/core/rsp_isqrt.sv]
`default_nettype none

module rsp_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rsp_pkg::SQ_W-1:0]   n_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [rsp_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int S = rsp_pkg::ISQRT_STEPS;
  localparam int W = rsp_pkg::ISQRT_W;

  logic [W-1:0]      in_rem [S];
  logic [W-1:0]      in_res [S];
  logic [SIDE_W-1:0] in_side [S];
  logic [W-1:0]      bitv [S];
  logic [W-1:0]      trial [S];
  logic [W-1:0]      rem_d [S];
  logic [W-1:0]      res_d [S];
  logic [W-1:0]      rem_q [S];
  logic [W-1:0]      res_q [S];
  logic [SIDE_W-1:0] side_q [S];

  always_comb begin
    in_rem[0]  = W'(n_i);
    in_res[0]  = '0;
    in_side[0] = side_i;
    for (int s = 1; s < S; s++) begin
      in_rem[s]  = rem_q[s-1];
      in_res[s]  = res_q[s-1];
      in_side[s] = side_q[s-1];
    end
    for (int s = 0; s < S; s++) begin
      bitv[s]  = W'(1) << (2 * (S - 1 - s));
      trial[s] = in_res[s] + bitv[s];
      if (in_rem[s] >= trial[s]) begin
        rem_d[s] = in_rem[s] - trial[s];
        res_d[s] = (in_res[s] >> 1) + bitv[s];
      end else begin
        rem_d[s] = in_rem[s];
        res_d[s] = in_res[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < S; s++) begin
        rem_q[s]  <= rem_d[s];
        res_q[s]  <= res_d[s];
        side_q[s] <= in_side[s];
      end
    end
  end

  assign root_o = res_q[S-1][rsp_pkg::ROOT_W-1:0];
  assign side_o = side_q[S-1];

endmodule

`default_nettype wire

[rtl/core/rsp_div.sv]
`default_nettype none

module rsp_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rsp_pkg::DIV_W-1:0]  num_x_i,
  input  logic [rsp_pkg::DIV_W-1:0]  num_y_i,
  input  logic [rsp_pkg::ROOT_W-1:0] den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic [rsp_pkg::QUOT_W-1:0] quot_x_o,
  output logic [rsp_pkg::QUOT_W-1:0] quot_y_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int S  = rsp_pkg::DIV_STEPS;
  localparam int W  = rsp_pkg::DIV_W;
  localparam int QW = rsp_pkg::QUOT_W;

  logic [W-1:0]              in_rx [S];
  logic [W-1:0]              in_ry [S];
  logic [QW-1:0]             in_qx [S];
  logic [QW-1:0]             in_qy [S];
  logic [rsp_pkg::ROOT_W-1:0] in_den [S];
  logic [SIDE_W-1:0]         in_side [S];
  logic [W-1:0]              trial [S];
  logic [W-1:0]              rx_d [S];
  logic [W-1:0]              ry_d [S];
  logic [QW-1:0]             qx_d [S];
  logic [QW-1:0]             qy_d [S];
  logic [W-1:0]              rx_q [S];
  logic [W-1:0]              ry_q [S];
  logic [QW-1:0]             qx_q [S];
  logic [QW-1:0]             qy_q [S];
  logic [rsp_pkg::ROOT_W-1:0] den_q [S];
  logic [SIDE_W-1:0]         side_q [S];

  always_comb begin
    in_rx[0]   = num_x_i;
    in_ry[0]   = num_y_i;
    in_qx[0]   = '0;
    in_qy[0]   = '0;
    in_den[0]  = den_i;
    in_side[0] = side_i;
    for (int s = 1; s < S; s++) begin
      in_rx[s]   = rx_q[s-1];
      in_ry[s]   = ry_q[s-1];
      in_qx[s]   = qx_q[s-1];
      in_qy[s]   = qy_q[s-1];
      in_den[s]  = den_q[s-1];
      in_side[s] = side_q[s-1];
    end
    for (int s = 0; s < S; s++) begin
      // Try the divisor scaled to this quotient bit.
      trial[s] = W'(in_den[s]) << (S - 1 - s);
      rx_d[s]  = in_rx[s];
      ry_d[s]  = in_ry[s];
      qx_d[s]  = in_qx[s];
      qy_d[s]  = in_qy[s];
      if (in_rx[s] >= trial[s]) begin
        rx_d[s] = in_rx[s] - trial[s];
        qx_d[s] = in_qx[s] | (QW'(1) << (S - 1 - s));
      end
      if (in_ry[s] >= trial[s]) begin
        ry_d[s] = in_ry[s] - trial[s];
        qy_d[s] = in_qy[s] | (QW'(1) << (S - 1 - s));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < S; s++) begin
        rx_q[s]   <= rx_d[s];
        ry_q[s]   <= ry_d[s];
        qx_q[s]   <= qx_d[s];
        qy_q[s]   <= qy_d[s];
        den_q[s]  <= in_den[s];
        side_q[s] <= in_side[s];
      end
    end
  end

  assign quot_x_o = qx_q[S-1];
  assign quot_y_o = qy_q[S-1];
  assign side_o   = side_q[S-1];

endmodule

`default_nettype wire

[rtl/core/rsp_axis.sv]
`default_nettype none

module rsp_axis #(
  parameter int COORD_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [COORD_BITS:0] dx_i,
  input  logic signed [COORD_BITS:0] dy_i,
  output rsp_pkg::axis_t         ax_o
);

  localparam int MW  = COORD_BITS + 1;
  localparam int IW  = $clog2(MW);
  localparam int NW  = rsp_pkg::NORM_W;
  localparam int XW  = MW + rsp_pkg::NORM_MSB;
  localparam int QW  = rsp_pkg::QUOT_W;
  localparam int AW  = rsp_pkg::AXIS_W;
  localparam int DW  = rsp_pkg::DIV_W;
  localparam int RW  = rsp_pkg::ROOT_W;
  localparam int SIW = 2 * NW + 3;

  // Stage 1: magnitudes and leading one of the larger one.
  logic [MW-1:0] mx, my, mm;
  logic [IW-1:0] msb;
  logic [MW-1:0] mx1_q, my1_q;
  logic [IW-1:0] msb1_q;
  logic          sx1_q, sy1_q, zero1_q;

  always_comb begin
    mx  = dx_i[MW-1] ? MW'(~dx_i + 1'b1) : MW'(dx_i);
    my  = dy_i[MW-1] ? MW'(~dy_i + 1'b1) : MW'(dy_i);
    mm  = (mx > my) ? mx : my;
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (mm[i]) begin
        msb = IW'(i);
      end
    end
  end

  // Stage 2: common shift putting the larger magnitude at the normal bit.
  logic [XW-1:0] wx, wy;
  logic [NW-1:0] nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic          sx2_q, sy2_q, zero2_q, sx3_q, sy3_q, zero3_q, sx4_q, sy4_q, zero4_q;
  logic [2*NW-1:0]          sqx3_q, sqy3_q;
  logic [rsp_pkg::SQ_W-1:0] n4_q;

  always_comb begin
    wx = {mx1_q, rsp_pkg::NORM_MSB'(0)} >> msb1_q;
    wy = {my1_q, rsp_pkg::NORM_MSB'(0)} >> msb1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx1_q   <= mx;
      my1_q   <= my;
      msb1_q  <= msb;
      sx1_q   <= dx_i[MW-1];
      sy1_q   <= dy_i[MW-1];
      zero1_q <= (mm == '0);
      nx2_q   <= wx[NW-1:0];
      ny2_q   <= wy[NW-1:0];
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      zero2_q <= zero1_q;
      sqx3_q  <= (2*NW)'(nx2_q) * (2*NW)'(nx2_q);
      sqy3_q  <= (2*NW)'(ny2_q) * (2*NW)'(ny2_q);
      nx3_q   <= nx2_q;
      ny3_q   <= ny2_q;
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
      zero3_q <= zero2_q;
      n4_q    <= rsp_pkg::SQ_W'(sqx3_q) + rsp_pkg::SQ_W'(sqy3_q);
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;
      zero4_q <= zero3_q;
    end
  end

  // Length of the normalized edge.
  logic [RW-1:0]  root;
  logic [SIW-1:0] side_sq;

  rsp_isqrt #(
    .SIDE_W (SIW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (n4_q),
    .side_i ({zero4_q, sy4_q, sx4_q, ny4_q, nx4_q}),
    .root_o (root),
    .side_o (side_sq)
  );

  // Numerators with half the divisor added for round-half-up.
  logic [DW-1:0] numx5_q, numy5_q;
  logic [RW-1:0] den5_q;
  logic [2:0]    flg5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx5_q <= (DW'(side_sq[NW-1:0]) << rsp_pkg::AXIS_FRAC) + DW'(root >> 1);
      numy5_q <= (DW'(side_sq[2*NW-1:NW]) << rsp_pkg::AXIS_FRAC) + DW'(root >> 1);
      den5_q  <= root;
      flg5_q  <= side_sq[SIW-1:2*NW];
    end
  end

  logic [QW-1:0] qx, qy;
  logic [2:0]    flg_dv;

  rsp_div #(
    .SIDE_W (3)
  ) u_div (
    .clk_i    (clk_i),
    .en_i     (en_i),
    .num_x_i  (numx5_q),
    .num_y_i  (numy5_q),
    .den_i    (den5_q),
    .side_i   (flg5_q),
    .quot_x_o (qx),
    .quot_y_o (qy),
    .side_o   (flg_dv)
  );

  // Apply the edge signs; a zero edge gives a zero axis.
  logic [AW-1:0]  qx_ext, qy_ext;
  rsp_pkg::axis_t ax_q;

  assign qx_ext = {1'b0, qx};
  assign qy_ext = {1'b0, qy};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (flg_dv[2]) begin
        ax_q <= '0;
      end else begin
        ax_q.x <= flg_dv[0] ? (~qx_ext + 1'b1) : qx_ext;
        ax_q.y <= flg_dv[1] ? (~qy_ext + 1'b1) : qy_ext;
      end
    end
  end

  assign ax_o = ax_q;

endmodule

`default_nettype wire

[rtl/core/rsp_resolve.sv]
`default_nettype none

module rsp_resolve #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_BITS+1:0]  cx_i [rsp_pkg::NUM_CORNERS],
  input  logic signed [COORD_BITS+1:0]  cy_i [rsp_pkg::NUM_CORNERS],
  input  rsp_pkg::axis_t                ax_i [rsp_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0]  push_x_o,
  output logic signed [COORD_BITS-1:0]  push_y_o,
  output logic                          overlap_o
);

  localparam int NA  = rsp_pkg::NUM_AXES;
  localparam int NC  = rsp_pkg::NUM_CORNERS;
  localparam int AF  = rsp_pkg::AXIS_FRAC;
  localparam int AW  = rsp_pkg::AXIS_W;
  localparam int CW  = COORD_BITS + 2;
  localparam int PW  = CW + AW;
  localparam int DW  = PW + 1;
  localparam int PSW = DW + 1;
  localparam int QW  = PSW - AF + 1;
  localparam int MPW = QW + AW;
  localparam int RW  = MPW - AF + 1;

  rsp_pkg::axis_t ax_q [6][NA];

  logic signed [PW-1:0]  prx_q [NA][NC];
  logic signed [PW-1:0]  pry_q [NA][NC];
  logic signed [DW-1:0]  dot_q [NA][NC];
  logic signed [DW-1:0]  loa_q [NA][2];
  logic signed [DW-1:0]  lob_q [NA][2];
  logic signed [DW-1:0]  hia_q [NA][2];
  logic signed [DW-1:0]  hib_q [NA][2];
  logic signed [DW-1:0]  lo_q  [NA][2];
  logic signed [DW-1:0]  hi_q  [NA][2];
  logic                  sep5_q [NA];
  logic signed [PSW-1:0] p1_q [NA];
  logic signed [PSW-1:0] p2_q [NA];
  logic signed [PSW-1:0] push_q [NA];
  logic                  sep6_q;
  logic signed [PSW-1:0] b01_q, b23_q, best_q;
  rsp_pkg::axis_t        a01_q, a23_q, abest_q, ab9_q;
  logic                  sep7_q, sep8_q, sep9_q, sep10_q;
  logic signed [QW-1:0]  p_q;
  logic signed [MPW-1:0] mpx_q, mpy_q;
  logic signed [COORD_BITS-1:0] push_x_q, push_y_q;
  logic                  ovl_q;

  // Magnitudes for the push choices.
  logic [PSW-1:0] m1 [NA];
  logic [PSW-1:0] m2 [NA];
  logic [PSW-1:0] mp [NA];
  logic [PSW-1:0] m01, m23;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      m1[k] = p1_q[k][PSW-1] ? PSW'(~p1_q[k] + 1'b1) : PSW'(p1_q[k]);
      m2[k] = p2_q[k][PSW-1] ? PSW'(~p2_q[k] + 1'b1) : PSW'(p2_q[k]);
      mp[k] = push_q[k][PSW-1] ? PSW'(~push_q[k] + 1'b1) : PSW'(push_q[k]);
    end
    m01 = b01_q[PSW-1] ? PSW'(~b01_q + 1'b1) : PSW'(b01_q);
    m23 = b23_q[PSW-1] ? PSW'(~b23_q + 1'b1) : PSW'(b23_q);
  end

  // Round the kept push to the coordinate grid, half away from zero.
  logic [PSW-1:0] mbest;
  logic [PSW:0]   sbest;
  logic [QW-1:0]  rbest;
  logic [MPW-1:0] mmx, mmy;
  logic [MPW:0]   smx, smy;
  logic [RW-1:0]  rmx, rmy;
  logic signed [RW-1:0] vx, vy;
  logic signed [RW-1:0] sat_hi, sat_lo;

  always_comb begin
    mbest  = best_q[PSW-1] ? PSW'(~best_q + 1'b1) : PSW'(best_q);
    sbest  = {1'b0, mbest} + (PSW+1)'(1 << (AF - 1));
    rbest  = sbest[PSW:AF];
    mmx    = mpx_q[MPW-1] ? MPW'(~mpx_q + 1'b1) : MPW'(mpx_q);
    mmy    = mpy_q[MPW-1] ? MPW'(~mpy_q + 1'b1) : MPW'(mpy_q);
    smx    = {1'b0, mmx} + (MPW+1)'(1 << (AF - 1));
    smy    = {1'b0, mmy} + (MPW+1)'(1 << (AF - 1));
    rmx    = smx[MPW:AF];
    rmy    = smy[MPW:AF];
    vx     = mpx_q[MPW-1] ? (~rmx + 1'b1) : rmx;
    vy     = mpy_q[MPW-1] ? (~rmy + 1'b1) : rmy;
    sat_hi = RW'($signed({1'b0, {(COORD_BITS-1){1'b1}}}));
    sat_lo = RW'($signed({1'b1, {(COORD_BITS-1){1'b0}}}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q[0] <= ax_i;
      for (int i = 1; i < 6; i++) begin
        ax_q[i] <= ax_q[i-1];
      end
      for (int k = 0; k < NA; k++) begin
        for (int j = 0; j < NC; j++) begin
          prx_q[k][j] <= PW'(cx_i[j]) * PW'(ax_i[k].x);
          pry_q[k][j] <= PW'(cy_i[j]) * PW'(ax_i[k].y);
          dot_q[k][j] <= DW'(prx_q[k][j]) + DW'(pry_q[k][j]);
        end
        for (int r = 0; r < 2; r++) begin
          loa_q[k][r] <= (dot_q[k][4*r] < dot_q[k][4*r+1]) ? dot_q[k][4*r] : dot_q[k][4*r+1];
          lob_q[k][r] <= (dot_q[k][4*r+2] < dot_q[k][4*r+3]) ?
                         dot_q[k][4*r+2] : dot_q[k][4*r+3];
          hia_q[k][r] <= (dot_q[k][4*r] > dot_q[k][4*r+1]) ? dot_q[k][4*r] : dot_q[k][4*r+1];
          hib_q[k][r] <= (dot_q[k][4*r+2] > dot_q[k][4*r+3]) ?
                         dot_q[k][4*r+2] : dot_q[k][4*r+3];
          lo_q[k][r]  <= (loa_q[k][r] < lob_q[k][r]) ? loa_q[k][r] : lob_q[k][r];
          hi_q[k][r]  <= (hia_q[k][r] > hib_q[k][r]) ? hia_q[k][r] : hib_q[k][r];
        end
        sep5_q[k] <= (hi_q[k][0] < lo_q[k][1]) || (hi_q[k][1] < lo_q[k][0]);
        p1_q[k]   <= PSW'(hi_q[k][1]) - PSW'(lo_q[k][0]);
        p2_q[k]   <= PSW'(lo_q[k][1]) - PSW'(hi_q[k][0]);
        push_q[k] <= (m1[k] < m2[k]) ? p1_q[k] : p2_q[k];
      end
      sep6_q <= sep5_q[0] || sep5_q[1] || sep5_q[2] || sep5_q[3];
      // Later axis wins only on a strictly smaller magnitude.
      b01_q  <= (mp[1] < mp[0]) ? push_q[1] : push_q[0];
      a01_q  <= (mp[1] < mp[0]) ? ax_q[5][1] : ax_q[5][0];
      b23_q  <= (mp[3] < mp[2]) ? push_q[3] : push_q[2];
      a23_q  <= (mp[3] < mp[2]) ? ax_q[5][3] : ax_q[5][2];
      sep7_q <= sep6_q;
      best_q  <= (m23 < m01) ? b23_q : b01_q;
      abest_q <= (m23 < m01) ? a23_q : a01_q;
      sep8_q  <= sep7_q;
      p_q     <= best_q[PSW-1] ? (~rbest + 1'b1) : rbest;
      ab9_q   <= abest_q;
      sep9_q  <= sep8_q;
      mpx_q   <= MPW'(p_q) * MPW'(ab9_q.x);
      mpy_q   <= MPW'(p_q) * MPW'(ab9_q.y);
      sep10_q <= sep9_q;
      if (sep10_q) begin
        push_x_q <= '0;
        push_y_q <= '0;
        ovl_q    <= 1'b0;
      end else begin
        push_x_q <= (vx > sat_hi) ? sat_hi[COORD_BITS-1:0] :
                    (vx < sat_lo) ? sat_lo[COORD_BITS-1:0] : vx[COORD_BITS-1:0];
        push_y_q <= (vy > sat_hi) ? sat_hi[COORD_BITS-1:0] :
                    (vy < sat_lo) ? sat_lo[COORD_BITS-1:0] : vy[COORD_BITS-1:0];
        ovl_q    <= (vx != '0) || (vy != '0);
      end
    end
  end

  assign push_x_o  = push_x_q;
  assign push_y_o  = push_y_q;
  assign overlap_o = ovl_q;

endmodule

`default_nettype wire
